@@ design/smf_pkg.sv @@
package smf_pkg;

   localparam int WINDOW      = 10;
   localparam int SAMPLE_BITS = 16;
   localparam int AXES        = 3;
   localparam int RANK_BITS   = $clog2(WINDOW);
   localparam int MID_LO      = (WINDOW - 1) / 2;
   localparam int MID_HI      = WINDOW / 2;

   localparam int AXIS_X = 0;
   localparam int AXIS_Y = 1;
   localparam int AXIS_Z = 2;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [SAMPLE_BITS:0]   pair_sum_type;
   typedef logic [RANK_BITS-1:0]          rank_type;

   typedef struct packed {
      sample_type mag_x;
      sample_type mag_y;
      sample_type mag_z;
   } smf_req_type;

   typedef struct packed {
      sample_type median_x;
      sample_type median_y;
      sample_type median_z;
   } smf_rsp_type;

endpackage

@@ design/smf_req_if.sv @@
interface smf_req_if;
   import smf_pkg::*;

   logic        valid;
   logic        ready;
   smf_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

@@ design/smf_rsp_if.sv @@
interface smf_rsp_if;
   import smf_pkg::*;

   logic        valid;
   logic        ready;
   smf_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

@@ design/sliding_median_filter_3axis_top.sv @@
// Channel   Direction  Handshake      Payload
// req_ch    in         valid/ready    mag_x, mag_y, mag_z (signed 16 b)
// rsp_ch    out        valid/ready    median_x, median_y, median_z (signed 16 b)
//
// One request per cycle sustained while rsp_ch.ready is high.
// Accept shifts the three window shift registers; a later advance ranks the ten
// entries per axis by parallel compare and loads the result register.
// Synchronous reset clears all windows to zero and empties both stages.
// A stalled result holds the rank stage; req_ch.ready drops only when both are full.
module sliding_median_filter_3axis_top (
   input logic       clock,
   input logic       reset,
   smf_req_if.sink   req_ch,
   smf_rsp_if.source rsp_ch
);
   import smf_pkg::*;

   sample_type   win_ff [AXES][WINDOW];
   sample_type   new_sample [AXES];
   rank_type     rank_cnt [AXES][WINDOW];
   sample_type   mid_lo [AXES];
   sample_type   mid_hi [AXES];
   pair_sum_type pair_sum [AXES];
   sample_type   median [AXES];

   logic        stage_valid_ff, stage_valid_in;
   logic        out_valid_ff, out_valid_in;
   smf_rsp_type out_ff, out_in;
   logic        req_ack;
   logic        advance;

   assign advance       = stage_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !stage_valid_ff || advance;
   assign req_ack       = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.payload = out_ff;

   assign new_sample[AXIS_X] = req_ch.payload.mag_x;
   assign new_sample[AXIS_Y] = req_ch.payload.mag_y;
   assign new_sample[AXIS_Z] = req_ch.payload.mag_z;

   // shift in the new request, drop the oldest
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            for (int i = 0; i < WINDOW; i++) begin
               win_ff[a][i] <= '0;
            end
         end
      end else if (req_ack) begin
         for (int a = 0; a < AXES; a++) begin
            win_ff[a][0] <= new_sample[a];
            for (int i = 1; i < WINDOW; i++) begin
               win_ff[a][i] <= win_ff[a][i-1];
            end
         end
      end
   end

   // rank by compare, ties broken by position
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         mid_lo[a] = '0;
         mid_hi[a] = '0;
         for (int i = 0; i < WINDOW; i++) begin
            rank_cnt[a][i] = '0;
            for (int j = 0; j < WINDOW; j++) begin
               if (j != i) begin
                  if ((win_ff[a][j] < win_ff[a][i]) ||
                      ((win_ff[a][j] == win_ff[a][i]) && (j < i))) begin
                     rank_cnt[a][i] = rank_cnt[a][i] + RANK_BITS'(1);
                  end
               end
            end
            if (rank_cnt[a][i] == RANK_BITS'(MID_LO)) begin
               mid_lo[a] = win_ff[a][i];
            end
            if (rank_cnt[a][i] == RANK_BITS'(MID_HI)) begin
               mid_hi[a] = win_ff[a][i];
            end
         end
         pair_sum[a] = {mid_lo[a][SAMPLE_BITS-1], mid_lo[a]} +
                       {mid_hi[a][SAMPLE_BITS-1], mid_hi[a]};
         median[a]   = pair_sum[a][SAMPLE_BITS:1];
      end
   end

   always_comb begin
      out_in.median_x = median[AXIS_X];
      out_in.median_y = median[AXIS_Y];
      out_in.median_z = median[AXIS_Z];
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_ack) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   a_advance_loads: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result register not loaded after advance");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_ack |=> stage_valid_ff)
      else $error("rank stage empty after accept");

   a_newest_entry: assert property (@(posedge clock) disable iff (reset)
      req_ack |=> (win_ff[AXIS_X][0] == $past(req_ch.payload.mag_x)))
      else $error("x window did not take the accepted request");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !advance) |-> !req_ch.ready)
      else $error("request taken while rank stage is held");

endmodule
